/* rtl/mkte_pkg.sv */
// Shared types, codes and letter tables for the multi-tap text entry block.
`timescale 1ns / 1ps

package mkte_pkg;

  localparam int CFG_DW = 16;
  localparam int ML_W   = 7;
  localparam int TO_W   = 16;
  localparam int KEY_W  = 4;
  localparam int PKEY_W = 5;
  localparam int TIME_W = 32;
  localparam int CHAR_W = 8;
  localparam int KIND_W = 2;
  localparam int LEN_W  = 6;

  localparam logic [ML_W-1:0] ML_RESET = 7'd64;
  localparam logic [TO_W-1:0] TO_RESET = 16'd1000;

  localparam logic REG_MAX_LENGTH = 1'b0;
  localparam logic REG_TIMEOUT    = 1'b1;

  localparam logic OP_KEY   = 1'b0;
  localparam logic OP_BEGIN = 1'b1;

  localparam logic [KEY_W-1:0] KEY_0      = 4'd0;
  localparam logic [KEY_W-1:0] KEY_2      = 4'd2;
  localparam logic [KEY_W-1:0] KEY_3      = 4'd3;
  localparam logic [KEY_W-1:0] KEY_4      = 4'd4;
  localparam logic [KEY_W-1:0] KEY_5      = 4'd5;
  localparam logic [KEY_W-1:0] KEY_6      = 4'd6;
  localparam logic [KEY_W-1:0] KEY_7      = 4'd7;
  localparam logic [KEY_W-1:0] KEY_8      = 4'd8;
  localparam logic [KEY_W-1:0] KEY_9      = 4'd9;
  localparam logic [KEY_W-1:0] KEY_CANCEL = 4'd10;
  localparam logic [KEY_W-1:0] KEY_SAVE   = 4'd13;
  localparam logic [KEY_W-1:0] KEY_STAR   = 4'd14;

  localparam logic [PKEY_W-1:0] NO_KEY = 5'd16;

  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SAVE,
    ST_DRAIN
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic walk;
  } ctrl_cmd_t;

  typedef struct packed {
    logic save_walk;
    logic walk_done;
  } dp_status_t;

  function automatic logic [CHAR_W-1:0] letter_code(input logic [KEY_W-1:0] key,
                                                    input logic [1:0]       pos);
    logic [CHAR_W-1:0] base;
    base = CHAR_A;
    unique case (key)
      KEY_2:   base = CHAR_A;
      KEY_3:   base = CHAR_A + 8'd3;
      KEY_4:   base = CHAR_A + 8'd6;
      KEY_5:   base = CHAR_A + 8'd9;
      KEY_6:   base = CHAR_A + 8'd12;
      KEY_7:   base = CHAR_A + 8'd15;
      KEY_8:   base = CHAR_A + 8'd19;
      KEY_9:   base = CHAR_A + 8'd22;
      default: base = CHAR_A;
    endcase
    return base + {6'd0, pos};
  endfunction

  function automatic logic [1:0] next_pos(input logic [KEY_W-1:0] key,
                                          input logic [1:0]       pos);
    logic [1:0] res;
    if (key == KEY_7 || key == KEY_9) begin
      res = pos + 2'd1;
    end else begin
      unique case (pos)
        2'd0:    res = 2'd1;
        2'd1:    res = 2'd2;
        2'd2:    res = 2'd0;
        default: res = 2'd1;
      endcase
    end
    return res;
  endfunction

endpackage

/* rtl/multitap_keypad_text_entry_core.sv */
// Top level of the multi-tap keypad text entry core.
`timescale 1ns / 1ps

// A transaction is taken when start_i is high and busy_o is low. A begin or
// key transaction, save of stored text apart, gives one status result, on
// the ports in the same cycle that busy_o falls. In a save of n characters
// the store is read one character per cycle through its single read port
// and each character comes out on its own cycle, back to back, the last
// one marked by last_o. Results are strobed by res_valid_o for one cycle
// each and cannot be held off. Configuration writes take effect at once and
// are meant for idle periods.

module multitap_keypad_text_entry_core #(
  parameter int TEXT_DEPTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [mkte_pkg::CFG_DW-1:0]     cfg_data_i,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            op_i,
  input  logic [mkte_pkg::KEY_W-1:0]      key_i,
  input  logic [mkte_pkg::TIME_W-1:0]     now_ms_i,
  output logic                            res_valid_o,
  output logic [mkte_pkg::KIND_W-1:0]     kind_o,
  output logic [mkte_pkg::CHAR_W-1:0]     char_out_o,
  output logic                            last_o,
  output logic                            changed_o,
  output logic [mkte_pkg::LEN_W-1:0]      text_length_o,
  output logic                            editing_o
);

  import mkte_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mkte_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  mkte_dpath #(
    .TEXT_DEPTH (TEXT_DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .op_i          (op_i),
    .key_i         (key_i),
    .now_ms_i      (now_ms_i),
    .res_valid_o   (res_valid_o),
    .kind_o        (kind_o),
    .char_out_o    (char_out_o),
    .last_o        (last_o),
    .changed_o     (changed_o),
    .text_length_o (text_length_o),
    .editing_o     (editing_o)
  );

  a_stream_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !last_o |=> res_valid_o && (kind_o == KIND_CHAR))
    else $error("saved text stream broken");

  a_char_after_save: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (kind_o == KIND_CHAR) |-> !editing_o && (text_length_o == '0))
    else $error("saved character while store not cleared");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o && !res_valid_o)
    else $error("accepted transaction not processed");

endmodule

/* rtl/mkte_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mkte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/mkte_ctrl.sv */
// Controller state machine: accept, execute, and walk the store on save.
`timescale 1ns / 1ps

module mkte_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  mkte_pkg::dp_status_t   status_i,
  output mkte_pkg::ctrl_cmd_t    cmd_o,
  output logic                   busy_o
);

  import mkte_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = status_i.save_walk ? ST_SAVE : ST_IDLE;
      end
      ST_SAVE: begin
        if (status_i.walk_done) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.load = (state_q == ST_IDLE) && start_i;
    cmd_o.exec = (state_q == ST_EXEC);
    cmd_o.walk = (state_q == ST_SAVE);
    busy_o     = (state_q != ST_IDLE);
  end

endmodule

/* rtl/mkte_dpath.sv */
// Datapath: configuration, text store, multi-tap state and result registers.
`timescale 1ns / 1ps

module mkte_dpath #(
  parameter int TEXT_DEPTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mkte_pkg::ctrl_cmd_t             cmd_i,
  output mkte_pkg::dp_status_t            status_o,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [mkte_pkg::CFG_DW-1:0]     cfg_data_i,
  input  logic                            op_i,
  input  logic [mkte_pkg::KEY_W-1:0]      key_i,
  input  logic [mkte_pkg::TIME_W-1:0]     now_ms_i,
  output logic                            res_valid_o,
  output logic [mkte_pkg::KIND_W-1:0]     kind_o,
  output logic [mkte_pkg::CHAR_W-1:0]     char_out_o,
  output logic                            last_o,
  output logic                            changed_o,
  output logic [mkte_pkg::LEN_W-1:0]      text_length_o,
  output logic                            editing_o
);

  import mkte_pkg::*;

  localparam int CW = $clog2(TEXT_DEPTH);
  localparam logic [ML_W-1:0] DEPTH_M1  = ML_W'(TEXT_DEPTH - 1);
  localparam logic [ML_W-1:0] DEPTH_CAP = ML_W'(TEXT_DEPTH);

  logic [ML_W-1:0]   ml_q;
  logic [TO_W-1:0]   to_q;
  logic              op_q;
  logic [KEY_W-1:0]  key_q;
  logic [TIME_W-1:0] now_q;

  logic [CW-1:0]     cnt_q, cnt_d;
  logic              active_q, active_d;
  logic [PKEY_W-1:0] pkey_q, pkey_d;
  logic [TIME_W-1:0] ptime_q, ptime_d;
  logic [1:0]        lpos_q, lpos_d;

  logic [CW-1:0]     rd_idx_q, rd_idx_d;
  logic [CW-1:0]     n_last_q, n_last_d;
  logic              rd_vld_q, rd_vld_d;
  logic              rd_last_q, rd_last_d;
  logic              save_chg_q, save_chg_d;

  logic              out_vld_q, out_vld_d;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic              last_q, last_d;
  logic              chg_q, chg_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              edit_q, edit_d;

  logic              we;
  logic [CW-1:0]     waddr;
  logic [CHAR_W-1:0] wdata;
  logic [CHAR_W-1:0] rdata;

  logic [ML_W-1:0]   cap7;
  logic [CW-1:0]     cap;
  logic [CW-1:0]     n_emit;
  logic              begin_ok;
  logic              is_digit;
  logic              rpt_hit;
  logic [TIME_W-1:0] elapsed;
  logic              save_walk;

  mkte_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (TEXT_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (rd_idx_q),
    .rdata_o (rdata)
  );

  always_comb begin
    cap7     = (ml_q == '0) ? '0 : ml_q - ML_W'(1);
    cap      = (cap7 > DEPTH_M1) ? CW'(DEPTH_M1) : CW'(cap7);
    n_emit   = (cnt_q > cap) ? cap : cnt_q;
    begin_ok = (ml_q != '0) && (ml_q <= DEPTH_CAP);
    is_digit = (key_q >= KEY_2) && (key_q <= KEY_9);
    elapsed  = now_q - ptime_q;
    rpt_hit  = (pkey_q == {1'b0, key_q}) && (elapsed < {16'd0, to_q});
    save_walk = (op_q == OP_KEY) && (key_q == KEY_SAVE) && active_q && (n_emit != '0);
  end

  assign status_o.save_walk = save_walk;
  assign status_o.walk_done = (rd_idx_q == n_last_q);

  always_comb begin
    cnt_d      = cnt_q;
    active_d   = active_q;
    pkey_d     = pkey_q;
    ptime_d    = ptime_q;
    lpos_d     = lpos_q;
    rd_idx_d   = rd_idx_q;
    n_last_d   = n_last_q;
    rd_vld_d   = 1'b0;
    rd_last_d  = rd_last_q;
    save_chg_d = save_chg_q;
    we         = 1'b0;
    waddr      = cnt_q;
    wdata      = CHAR_SPACE;
    out_vld_d  = 1'b0;
    kind_d     = KIND_STATUS;
    char_d     = '0;
    last_d     = 1'b1;
    chg_d      = 1'b0;

    if (cmd_i.exec) begin
      if (op_q == OP_BEGIN) begin
        if (begin_ok) begin
          active_d = 1'b1;
          cnt_d    = '0;
          pkey_d   = NO_KEY;
          ptime_d  = '0;
          lpos_d   = '0;
        end
      end else begin
        priority if (key_q == KEY_SAVE) begin
          if (active_q) begin
            chg_d      = (cnt_q != '0);
            save_chg_d = (cnt_q != '0);
            cnt_d      = '0;
            active_d   = 1'b0;
            rd_idx_d   = '0;
            n_last_d   = n_emit - CW'(1);
            if (n_emit == '0) kind_d = KIND_EMPTY;
          end
        end else if (key_q == KEY_CANCEL) begin
          chg_d    = (cnt_q != '0);
          cnt_d    = '0;
          active_d = 1'b0;
        end else if (key_q == KEY_STAR) begin
          if (cnt_q != '0) begin
            cnt_d = cnt_q - CW'(1);
            chg_d = 1'b1;
          end
        end else if (key_q == KEY_0) begin
          if (active_q && (cnt_q < cap)) begin
            we    = 1'b1;
            wdata = CHAR_SPACE;
            cnt_d = cnt_q + CW'(1);
            chg_d = 1'b1;
          end
        end else if (is_digit) begin
          if (rpt_hit) begin
            lpos_d = next_pos(key_q, lpos_q);
            if (cnt_q != '0) begin
              we    = 1'b1;
              waddr = cnt_q - CW'(1);
              wdata = letter_code(key_q, lpos_d);
              chg_d = 1'b1;
            end
          end else begin
            lpos_d = '0;
            if (active_q && (cnt_q < cap)) begin
              we    = 1'b1;
              wdata = letter_code(key_q, 2'd0);
              cnt_d = cnt_q + CW'(1);
              chg_d = 1'b1;
            end
          end
          pkey_d  = {1'b0, key_q};
          ptime_d = now_q;
        end else begin
          chg_d = 1'b0;
        end
      end
      out_vld_d = !save_walk;
    end

    if (cmd_i.walk) begin
      rd_idx_d  = rd_idx_q + CW'(1);
      rd_vld_d  = 1'b1;
      rd_last_d = (rd_idx_q == n_last_q);
    end

    if (rd_vld_q) begin
      out_vld_d = 1'b1;
      kind_d    = KIND_CHAR;
      char_d    = rdata;
      last_d    = rd_last_q;
      chg_d     = save_chg_q;
    end

    len_d  = LEN_W'(cnt_d);
    edit_d = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ml_q      <= ML_RESET;
      to_q      <= TO_RESET;
      cnt_q     <= '0;
      active_q  <= 1'b0;
      pkey_q    <= NO_KEY;
      ptime_q   <= '0;
      lpos_q    <= '0;
      rd_idx_q  <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MAX_LENGTH: ml_q <= cfg_data_i[ML_W-1:0];
          REG_TIMEOUT:    to_q <= cfg_data_i[TO_W-1:0];
          default:        ml_q <= ml_q;
        endcase
      end
      cnt_q     <= cnt_d;
      active_q  <= active_d;
      pkey_q    <= pkey_d;
      ptime_q   <= ptime_d;
      lpos_q    <= lpos_d;
      rd_idx_q  <= rd_idx_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      key_q <= key_i;
      now_q <= now_ms_i;
    end
    n_last_q   <= n_last_d;
    rd_last_q  <= rd_last_d;
    save_chg_q <= save_chg_d;
    kind_q     <= kind_d;
    char_q     <= char_d;
    last_q     <= last_d;
    chg_q      <= chg_d;
    len_q      <= len_d;
    edit_q     <= edit_d;
  end

  assign res_valid_o   = out_vld_q;
  assign kind_o        = kind_q;
  assign char_out_o    = char_q;
  assign last_o        = last_q;
  assign changed_o     = chg_q;
  assign text_length_o = len_q;
  assign editing_o     = edit_q;

endmodule

/* dv/multitap_keypad_text_entry_core_tb.sv */
// Self-checking testbench for the multi-tap keypad text entry core.
`timescale 1ns / 1ps

module multitap_keypad_text_entry_core_tb;
  import mkte_pkg::*;

  localparam int DEPTH    = 64;
  localparam int HALF     = 4;
  localparam int SETTLE   = 6;
  localparam int WATCHDOG = 3000;
  localparam int PHASES   = 6;
  localparam int PHASE_N  = 50;

  localparam logic [KEY_W-1:0] KEY_1    = 4'd1;
  localparam logic [KEY_W-1:0] KEY_B    = 4'd11;
  localparam logic [KEY_W-1:0] KEY_C    = 4'd12;
  localparam logic [KEY_W-1:0] KEY_HASH = 4'd15;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              changed;
    logic [LEN_W-1:0]  len;
    logic              editing;
  } entry_res_t;

  typedef struct packed {
    bit                is_reg;
    logic              op;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
    logic              reg_idx;
    logic [CFG_DW-1:0] reg_val;
    bit                fixed;
    entry_res_t        res;
  } script_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_idx_i = 1'b0;
  logic [CFG_DW-1:0]   cfg_data_i = '0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic                op_i = 1'b0;
  logic [KEY_W-1:0]    key_i = '0;
  logic [TIME_W-1:0]   now_ms_i = '0;
  logic                res_valid_o;
  logic [KIND_W-1:0]   kind_o;
  logic [CHAR_W-1:0]   char_out_o;
  logic                last_o;
  logic                changed_o;
  logic [LEN_W-1:0]    text_length_o;
  logic                editing_o;

  // sideband that travels with each presented transaction
  bit                  fixed_row = 1'b0;
  entry_res_t          fixed_res = '0;

  logic [CHAR_W-1:0]   text_mem [DEPTH];
  logic [ML_W-1:0]     text_count;
  logic                sess_on;
  logic [PKEY_W-1:0]   last_key;
  logic [TIME_W-1:0]   last_press_ms;
  logic [1:0]          letter_idx;
  logic [ML_W-1:0]     max_len;
  logic [TO_W-1:0]     timeout_ms;

  entry_res_t          step_results [$];
  entry_res_t          owed_results [$];
  script_row_t         script [$];

  int                  idle_pct = 0;
  int                  err_count = 0;
  int                  items_taken = 0;
  int                  results_seen = 0;
  int                  idle_cycles = 0;

  always #(HALF) clk_i = ~clk_i;

  multitap_keypad_text_entry_core #(
    .TEXT_DEPTH(DEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .op_i         (op_i),
    .key_i        (key_i),
    .now_ms_i     (now_ms_i),
    .res_valid_o  (res_valid_o),
    .kind_o       (kind_o),
    .char_out_o   (char_out_o),
    .last_o       (last_o),
    .changed_o    (changed_o),
    .text_length_o(text_length_o),
    .editing_o    (editing_o)
  );

  function automatic string letters_on(input logic [KEY_W-1:0] key);
    case (key)
      KEY_2:   return "ABC";
      KEY_3:   return "DEF";
      KEY_4:   return "GHI";
      KEY_5:   return "JKL";
      KEY_6:   return "MNO";
      KEY_7:   return "PQRS";
      KEY_8:   return "TUV";
      KEY_9:   return "WXYZ";
      default: return "";
    endcase
  endfunction

  function automatic int text_cap();
    int c;
    c = (max_len == 0) ? 0 : int'(max_len) - 1;
    if (c > DEPTH - 1) c = DEPTH - 1;
    return c;
  endfunction

  function automatic logic append_char(input logic [CHAR_W-1:0] c);
    if (!sess_on || int'(text_count) >= text_cap()) return 1'b0;
    text_mem[text_count] = c;
    text_count++;
    return 1'b1;
  endfunction

  function automatic void log_result(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                                     input logic last, input logic chg);
    entry_res_t r;
    r.kind    = kind;
    r.ch      = ch;
    r.last    = last;
    r.changed = chg;
    r.len     = text_count[LEN_W-1:0];
    r.editing = sess_on;
    step_results.push_back(r);
  endfunction

  task automatic apply_keypress(input logic op, input logic [KEY_W-1:0] key,
                                input logic [TIME_W-1:0] now);
    int    n;
    int    cnt;
    int    nxt;
    logic  chg;
    string letters;
    step_results.delete();
    chg = 1'b0;
    if (op == OP_BEGIN) begin
      if (max_len != 0 && int'(max_len) <= DEPTH) begin
        sess_on       = 1'b1;
        text_count    = '0;
        last_key      = NO_KEY;
        last_press_ms = '0;
        letter_idx    = '0;
      end
      log_result(KIND_STATUS, '0, 1'b1, 1'b0);
    end else if (key == KEY_SAVE && sess_on) begin
      n = int'(text_count);
      if (n > text_cap()) n = text_cap();
      chg        = text_count != 0;
      text_count = '0;
      sess_on    = 1'b0;
      if (n == 0) begin
        log_result(KIND_EMPTY, '0, 1'b1, chg);
      end else begin
        for (int i = 0; i < n; i++) log_result(KIND_CHAR, text_mem[i], i == n - 1, chg);
      end
    end else begin
      case (key)
        KEY_CANCEL: begin
          chg        = text_count != 0;
          text_count = '0;
          sess_on    = 1'b0;
        end
        KEY_STAR: begin
          if (text_count != 0) begin
            text_count--;
            chg = 1'b1;
          end
        end
        KEY_0: begin
          chg = append_char(CHAR_SPACE);
        end
        KEY_2, KEY_3, KEY_4, KEY_5, KEY_6, KEY_7, KEY_8, KEY_9: begin
          letters = letters_on(key);
          cnt     = letters.len();
          if (last_key == {1'b0, key} && (now - last_press_ms) < {16'd0, timeout_ms}) begin
            nxt        = (int'(letter_idx) + 1) % cnt;
            letter_idx = nxt[1:0];
            if (text_count != 0) begin
              text_mem[text_count - 1] = letters[letter_idx];
              chg = 1'b1;
            end
          end else begin
            letter_idx = '0;
            chg        = append_char(letters[0]);
          end
          last_key      = {1'b0, key};
          last_press_ms = now;
        end
        default: begin
        end
      endcase
      log_result(KIND_STATUS, '0, 1'b1, chg);
    end
  endtask

  function automatic void report_miss(input string what, input entry_res_t want,
                                      input entry_res_t got);
    err_count++;
    if (err_count <= 10) begin
      $display("%s at %0t: expected kind %0d char %02h last %0d changed %0d len %0d editing %0d",
               what, $time, want.kind, want.ch, want.last, want.changed, want.len, want.editing);
      $display("    got kind %0d char %02h last %0d changed %0d len %0d editing %0d",
               got.kind, got.ch, got.last, got.changed, got.len, got.editing);
    end
  endfunction

  always @(posedge clk_i) begin
    entry_res_t got;
    entry_res_t want;
    if (rst_ni) begin
      if (res_valid_o) begin
        got.kind    = kind_o;
        got.ch      = char_out_o;
        got.last    = last_o;
        got.changed = changed_o;
        got.len     = text_length_o;
        got.editing = editing_o;
        results_seen++;
        if (owed_results.size() == 0) begin
          report_miss("unexpected result", '0, got);
        end else begin
          want = owed_results.pop_front();
          if (got !== want) report_miss("mismatch", want, got);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_MAX_LENGTH) max_len = cfg_data_i[ML_W-1:0];
        else timeout_ms = cfg_data_i[TO_W-1:0];
      end
      if (start_i && !busy_o) begin
        items_taken++;
        apply_keypress(op_i, key_i, now_ms_i);
        if (fixed_row) owed_results.push_back(fixed_res);
        else foreach (step_results[i]) owed_results.push_back(step_results[i]);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               WATCHDOG, owed_results.size());
      $display("multitap_keypad_text_entry_core_tb: errors");
      $finish;
    end
  end

  task automatic present(input logic op, input logic [KEY_W-1:0] key,
                         input logic [TIME_W-1:0] now, input bit fixed, input entry_res_t res);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i   <= 1'b1;
    op_i      <= op;
    key_i     <= key;
    now_ms_i  <= now;
    fixed_row <= fixed;
    fixed_res <= res;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic settle();
    start_i <= 1'b0;
    do @(negedge clk_i); while (owed_results.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DW-1:0] val);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic void add_key(input logic op, input logic [KEY_W-1:0] key,
                                  input logic [TIME_W-1:0] now);
    script_row_t r;
    r     = '0;
    r.op  = op;
    r.key = key;
    r.now = now;
    script.push_back(r);
  endfunction

  function automatic void add_fixed(input logic op, input logic [KEY_W-1:0] key,
                                    input logic [TIME_W-1:0] now, input entry_res_t res);
    script_row_t r;
    r       = '0;
    r.op    = op;
    r.key   = key;
    r.now   = now;
    r.fixed = 1'b1;
    r.res   = res;
    script.push_back(r);
  endfunction

  function automatic void add_reg(input logic idx, input logic [CFG_DW-1:0] val);
    script_row_t r;
    r         = '0;
    r.is_reg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    script.push_back(r);
  endfunction

  initial begin
    int                ph;
    int                pick;
    int                cur_len;
    int                cur_to;
    int                save_pct;
    bit                gen_editing;
    logic              op;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  last_digit;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] tick;

    text_count    = '0;
    sess_on       = 1'b0;
    last_key      = NO_KEY;
    last_press_ms = '0;
    letter_idx    = '0;
    max_len       = ML_RESET;
    timeout_ms    = TO_RESET;

    add_fixed(OP_KEY,   KEY_SAVE,   32'h0000_0000, '{KIND_STATUS, 8'h00, 1'b1, 1'b0, 6'd0, 1'b0});
    add_fixed(OP_KEY,   KEY_2,      32'h0000_0000, '{KIND_STATUS, 8'h00, 1'b1, 1'b0, 6'd0, 1'b0});
    add_fixed(OP_BEGIN, KEY_HASH,   32'hFFFF_FFFF, '{KIND_STATUS, 8'h00, 1'b1, 1'b0, 6'd0, 1'b1});
    add_fixed(OP_KEY,   KEY_STAR,   32'h0000_000A, '{KIND_STATUS, 8'h00, 1'b1, 1'b0, 6'd0, 1'b1});
    add_key(OP_KEY, KEY_2,    32'h0000_0064);
    add_key(OP_KEY, KEY_STAR, 32'h0000_0096);
    add_key(OP_KEY, KEY_2,    32'h0000_00C8);
    add_key(OP_KEY, KEY_7,    32'h0000_0190);
    add_key(OP_KEY, KEY_7,    32'h0000_01F4);
    add_key(OP_KEY, KEY_9,    32'hFFFF_FFFF);
    add_key(OP_KEY, KEY_9,    32'h0000_0011);
    add_key(OP_KEY, KEY_9,    32'h0000_03F9);
    add_key(OP_KEY, KEY_0,    32'h0000_03FA);
    add_key(OP_KEY, KEY_9,    32'h0000_0400);
    add_key(OP_KEY, KEY_SAVE, 32'h0000_0500);
    add_fixed(OP_KEY, KEY_CANCEL, 32'h0000_0600, '{KIND_STATUS, 8'h00, 1'b1, 1'b0, 6'd0, 1'b0});
    add_reg(REG_MAX_LENGTH, 16'd3);
    add_key(OP_BEGIN, KEY_0, 32'h0000_0000);
    add_key(OP_KEY,   KEY_3, 32'h0000_0000);
    add_key(OP_KEY,   KEY_4, 32'h0000_0000);
    add_key(OP_KEY,   KEY_5, 32'h0000_0000);
    add_key(OP_KEY,   KEY_0, 32'h0000_0000);
    add_reg(REG_MAX_LENGTH, 16'd2);
    add_key(OP_KEY,   KEY_SAVE, 32'h0000_0000);
    add_key(OP_BEGIN, KEY_0,    32'h0000_0000);
    add_key(OP_KEY,   KEY_6,    32'h0000_0000);
    add_reg(REG_MAX_LENGTH, 16'd0);
    add_fixed(OP_BEGIN, KEY_0,    32'h0000_0000, '{KIND_STATUS, 8'h00, 1'b1, 1'b0, 6'd1, 1'b1});
    add_fixed(OP_KEY,   KEY_SAVE, 32'h0000_0000, '{KIND_EMPTY,  8'h00, 1'b1, 1'b1, 6'd0, 1'b0});
    add_reg(REG_MAX_LENGTH, 16'd100);
    add_fixed(OP_BEGIN, KEY_0,    32'h0000_0000, '{KIND_STATUS, 8'h00, 1'b1, 1'b0, 6'd0, 1'b0});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].is_reg) write_reg(script[i].reg_idx, script[i].reg_val);
      else present(script[i].op, script[i].key, script[i].now, script[i].fixed, script[i].res);
    end

    tick = $urandom;
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin cur_len = 64; cur_to = 1000;  idle_pct = 0;  save_pct = 8; end
        1:       begin cur_len = 1;  cur_to = 65535; idle_pct = 60; save_pct = 8; end
        2:       begin cur_len = 8;  cur_to = 65535; idle_pct = 0;  save_pct = 8; end
        3:       begin cur_len = 64; cur_to = 1;     idle_pct = 60; save_pct = 2; end
        4:       begin
          cur_len  = $urandom_range(64, 1);
          cur_to   = $urandom_range(65535, 1);
          idle_pct = 36;
          save_pct = 6;
        end
        default: begin cur_len = 5;  cur_to = 300;   idle_pct = 0;  save_pct = 8; end
      endcase
      write_reg(REG_MAX_LENGTH, cur_len[CFG_DW-1:0]);
      write_reg(REG_TIMEOUT, cur_to[CFG_DW-1:0]);
      gen_editing = 1'b0;
      last_digit  = KEY_2;
      for (int n = 0; n < PHASE_N; n++) begin
        pick = $urandom_range(99);
        if (pick < 70) tick = tick + $urandom_range(cur_to - 1, 0);
        else if (pick < 90) tick = tick + cur_to + $urandom_range(100);
        else tick = tick + $urandom;
        op   = OP_KEY;
        key  = KEY_1;
        now  = tick;
        pick = $urandom_range(99);
        if (!gen_editing) begin
          if (pick < 80) begin
            op  = OP_BEGIN;
            key = KEY_W'($urandom_range(15));
          end else begin
            op  = 1'($urandom_range(1));
            key = KEY_W'($urandom_range(15));
            now = $urandom;
          end
        end else if (pick < 50) begin
          key = ($urandom_range(1) != 0) ? last_digit : KEY_W'($urandom_range(9, 2));
          last_digit = key;
        end else if (pick < 60) begin
          key = KEY_0;
        end else if (pick < 70) begin
          key = KEY_STAR;
        end else if (pick < 70 + save_pct) begin
          key = KEY_SAVE;
        end else if (pick < 74 + save_pct) begin
          key = KEY_CANCEL;
        end else if (pick < 80 + save_pct) begin
          case ($urandom_range(3))
            0:       key = KEY_1;
            1:       key = KEY_B;
            2:       key = KEY_C;
            default: key = KEY_HASH;
          endcase
        end else if (pick < 82 + save_pct) begin
          op = OP_BEGIN;
        end else begin
          op  = 1'($urandom_range(1));
          key = KEY_W'($urandom_range(15));
          now = $urandom;
        end
        if (op == OP_BEGIN) gen_editing = 1'b1;
        else if (key == KEY_SAVE || key == KEY_CANCEL) gen_editing = 1'b0;
        present(op, key, now, 1'b0, '0);
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    $display("run covered %0d transactions (%0d scripted rows, %0d random phases) and %0d results",
             items_taken, script.size(), PHASES, results_seen);
    $display("capacities 0 to 100 and repeat windows 1 to 65535 ms, %0d mismatches", err_count);
    if (err_count == 0) begin
      $display("multitap_keypad_text_entry_core_tb: clean");
    end else begin
      $display("multitap_keypad_text_entry_core_tb: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/mkte_pkg.sv
rtl/mkte_ram.sv
rtl/mkte_ctrl.sv
rtl/mkte_dpath.sv
rtl/multitap_keypad_text_entry_core.sv
dv/multitap_keypad_text_entry_core_tb.sv
